// ===== rtl/hlxfp_pkg.sv =====
// ----------------------------------------------------------------------------
// hlxfp_pkg
// Shared types and constants of the header / length / xor frame parser.
// ----------------------------------------------------------------------------
package hlxfp_pkg;

  // payload buffer geometry
  localparam int BUF_DEPTH = 32;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

  // frame overhead: two header bytes, length, function, checksum
  localparam int OVERHEAD  = 5;

  // header pattern after reset
  localparam logic [15:0] HEADER_RESET = 16'hABBC;

  // result status codes
  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_OK       = 3'd1,
    ST_HDR_ERR  = 3'd2,
    ST_SIZE_ERR = 3'd3,
    ST_CSUM_ERR = 3'd4
  } status_t;

  // parser phases
  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_LEN,
    PH_FUNC,
    PH_DATA,
    PH_CSUM,
    PH_RD,
    PH_EMIT
  } phase_t;

endpackage

// ===== rtl/hlxfp_if.sv =====
// ----------------------------------------------------------------------------
// hlxfp_if
// Valid/ready channels of the frame parser: byte input and result output.
// ----------------------------------------------------------------------------
interface hlxfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface hlxfp_out_if;
  import hlxfp_pkg::*;

  logic       valid;
  logic       ready;
  status_t    status;
  logic [7:0] function_code;
  logic [5:0] payload_count;
  logic [7:0] payload_byte;
  logic [4:0] payload_index;
  logic       last;

  modport source (output valid, output status, output function_code,
                  output payload_count, output payload_byte,
                  output payload_index, output last, input ready);
  modport sink   (input valid, input status, input function_code,
                  input payload_count, input payload_byte,
                  input payload_index, input last, output ready);
endinterface

// ===== rtl/hlxfp_store.sv =====
// ----------------------------------------------------------------------------
// hlxfp_store
// Payload buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hlxfp_store (
  input  logic                      clk,
  input  logic                      we,
  input  logic [hlxfp_pkg::ADDR_W-1:0] waddr,
  input  logic [7:0]                wdata,
  input  logic [hlxfp_pkg::ADDR_W-1:0] raddr,
  output logic [7:0]                rdata
);
  import hlxfp_pkg::*;

  logic [7:0] mem [BUF_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/header_length_xor_frame_parser.sv =====
// ----------------------------------------------------------------------------
// header_length_xor_frame_parser
// Parses header / length / function / payload / xor-checksum frames from a
// byte stream and replays the payload of each good frame.
// ----------------------------------------------------------------------------
// Every accepted input byte yields one status beat, one cycle per byte while
// the output register drains. A frame with a good checksum instead yields its
// payload as a run of max(1, length-5) beats marked last on the final one;
// each payload beat is a read of the payload memory, then the load of the
// output register, and no input byte is taken during the run.
// Any header, size or checksum error returns the parser to header hunting.
// The two-byte header pattern is written through cfg_we/cfg_data and resets
// to 0xABBC.
module header_length_xor_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  hlxfp_in_if.sink    rx,
  hlxfp_out_if.source res
);
  import hlxfp_pkg::*;

  phase_t             phase;
  phase_t             phase_next;
  logic [15:0]        header;
  logic [7:0]         first_byte;
  logic [7:0]         first_byte_next;
  logic [7:0]         run_xor;
  logic [7:0]         run_xor_next;
  logic [CNT_W-1:0]   plen;
  logic [CNT_W-1:0]   plen_next;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_next;
  logic [7:0]         func;
  logic [7:0]         func_next;
  logic [ADDR_W-1:0]  idx;
  logic [ADDR_W-1:0]  idx_next;

  logic               out_free;
  logic               parsing;
  logic               fire;
  logic [7:0]         b;
  logic               hdr_match;
  logic               size_bad;
  logic               data_done;
  logic               emit_last;
  logic               mem_we;
  logic [7:0]         rdata;

  logic               res_load;
  status_t            st_next;
  logic [7:0]         fc_next;
  logic [5:0]         pc_next;
  logic [7:0]         pb_next;
  logic [4:0]         pi_next;
  logic               last_next;

  // handshake
  assign out_free = !res.valid || res.ready;
  assign parsing  = (phase != PH_RD) && (phase != PH_EMIT);
  assign rx.ready = !rst && parsing && out_free;
  assign fire     = rx.valid && rx.ready;
  assign b        = rx.byte_in;

  // byte checks
  assign hdr_match = ({first_byte, b} == header);
  assign size_bad  = (b < 8'(OVERHEAD)) || ({1'b0, b} > 9'(BUF_DEPTH + OVERHEAD));
  assign data_done = (CNT_W'(cnt + CNT_W'(1)) >= plen);
  assign emit_last = (CNT_W'({1'b0, idx} + CNT_W'(1)) == plen);

  // payload memory
  assign mem_we = fire && (phase == PH_DATA);

  hlxfp_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cnt[ADDR_W-1:0]),
    .wdata (b),
    .raddr (idx),
    .rdata (rdata)
  );

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HDR0: if (fire) phase_next = PH_HDR1;
      PH_HDR1: if (fire) phase_next = hdr_match ? PH_LEN : PH_HDR0;
      PH_LEN:  if (fire) phase_next = size_bad ? PH_HDR0 : PH_FUNC;
      PH_FUNC: if (fire) phase_next = (plen == '0) ? PH_CSUM : PH_DATA;
      PH_DATA: if (fire && data_done) phase_next = PH_CSUM;
      PH_CSUM: begin
        if (fire) begin
          if ((b != run_xor) || (plen == '0)) phase_next = PH_HDR0;
          else phase_next = PH_RD;
        end
      end
      PH_RD:   phase_next = PH_EMIT;
      PH_EMIT: if (out_free) phase_next = emit_last ? PH_HDR0 : PH_RD;
    endcase
  end

  // datapath and result selection
  always_comb begin
    first_byte_next = first_byte;
    run_xor_next    = run_xor;
    plen_next       = plen;
    cnt_next        = cnt;
    func_next       = func;
    idx_next        = idx;
    res_load        = 1'b0;
    st_next         = ST_BUSY;
    fc_next         = '0;
    pc_next         = '0;
    pb_next         = '0;
    pi_next         = '0;
    last_next       = 1'b1;
    unique case (phase)
      PH_HDR0: begin
        if (fire) begin
          first_byte_next = b;
          run_xor_next    = b;
          res_load        = 1'b1;
        end
      end
      PH_HDR1: begin
        if (fire) begin
          res_load = 1'b1;
          if (hdr_match) run_xor_next = run_xor ^ b;
          else st_next = ST_HDR_ERR;
        end
      end
      PH_LEN: begin
        if (fire) begin
          res_load  = 1'b1;
          plen_next = CNT_W'(b - 8'(OVERHEAD));
          if (size_bad) st_next = ST_SIZE_ERR;
          else run_xor_next = run_xor ^ b;
        end
      end
      PH_FUNC: begin
        if (fire) begin
          res_load     = 1'b1;
          func_next    = b;
          run_xor_next = run_xor ^ b;
          cnt_next     = '0;
        end
      end
      PH_DATA: begin
        if (fire) begin
          res_load     = 1'b1;
          run_xor_next = run_xor ^ b;
          cnt_next     = CNT_W'(cnt + CNT_W'(1));
        end
      end
      PH_CSUM: begin
        if (fire) begin
          idx_next = '0;
          if (b != run_xor) begin
            res_load = 1'b1;
            st_next  = ST_CSUM_ERR;
          end else if (plen == '0) begin
            res_load = 1'b1;
            st_next  = ST_OK;
            fc_next  = func;
          end
        end
      end
      PH_RD: begin
      end
      PH_EMIT: begin
        if (out_free) begin
          res_load  = 1'b1;
          st_next   = ST_OK;
          fc_next   = func;
          pc_next   = 6'(plen);
          pb_next   = rdata;
          pi_next   = 5'(idx);
          last_next = emit_last;
          idx_next  = ADDR_W'(idx + ADDR_W'(1));
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR0;
      header    <= HEADER_RESET;
      res.valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (cfg_we) header <= cfg_data;
      if (res_load) res.valid <= 1'b1;
      else if (res.ready) res.valid <= 1'b0;
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    first_byte <= first_byte_next;
    run_xor    <= run_xor_next;
    plen       <= plen_next;
    cnt        <= cnt_next;
    func       <= func_next;
    idx        <= idx_next;
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (res_load) begin
      res.status        <= st_next;
      res.function_code <= fc_next;
      res.payload_count <= pc_next;
      res.payload_byte  <= pb_next;
      res.payload_index <= pi_next;
      res.last          <= last_next;
    end
  end

endmodule
